// ----- rtl/gfk_pkg.sv -----
`default_nettype none
package gfk_pkg;

  localparam int NUM_W = 27;
  localparam logic [NUM_W-1:0] TWO_PI_Q24 = 27'd105414357;
  localparam int F_W = 16;
  localparam int D_W = 36;
  localparam int G_W = 31;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 4'd0,
    CFG_CENTER_Y = 4'd1,
    CFG_GAUSS    = 4'd2,
    CFG_PREFAC   = 4'd3,
    CFG_DC_FREE  = 4'd4,
    CFG_EPSILON  = 4'd5,
    CFG_WIDTH    = 4'd6,
    CFG_HEIGHT   = 4'd7
  } cfg_idx_e;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end else begin
      return -((-v + half) >>> s);
    end
  endfunction

  function automatic logic [G_W-1:0] exp_entry(input longint r, input int i);
    longint e;
    e = longint'(1) <<< 30;
    for (int k = 1; k <= i; k++) begin
      e = (e * r + (longint'(1) <<< 29)) >>> 30;
    end
    return e[G_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gfk_div.sv -----
`default_nettype none
module gfk_div import gfk_pkg::*; #(
  parameter int DIM_W = 10,
  parameter logic [NUM_W-1:0] RST_Q = '0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIM_W-1:0] n_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      q_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] w_q;
  logic [DIM_W-1:0] rem_q;
  logic [DIM_W-1:0] n_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIM_W:0]   remx;
  logic             ge;

  assign remx = {rem_q, w_q[NUM_W-1]};
  assign ge   = remx >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= RST_Q;
      rem_q <= '0;
      n_q   <= DIM_W'(1);
      cnt_q <= '0;
    end else if (start_i) begin
      w_q   <= TWO_PI_Q24 + NUM_W'(n_i >> 1);
      rem_q <= '0;
      n_q   <= n_i;
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DIM_W'(remx - {1'b0, n_q}) : DIM_W'(remx);
      w_q   <= {w_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign busy_o = cnt_q != '0;
  assign q_o    = w_q;

endmodule
`default_nettype wire

// ----- rtl/gfk_gauss.sv -----
`default_nettype none
module gfk_gauss import gfk_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [23:0]    coef_i,
  input  wire logic [D_W-1:0] d_i,
  output logic [G_W-1:0]      g_o
);

  localparam int TI_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int P_W = 20 + TI_W;
  localparam longint H = (longint'(16) <<< 30) / EXP_TABLE_DEPTH;
  localparam longint Q30 = longint'(1) <<< 30;
  localparam longint T1  = (Q30 * H) / (longint'(1) <<< 30);
  localparam longint T2  = (T1 * H) / (longint'(2) <<< 30);
  localparam longint T3  = (T2 * H) / (longint'(3) <<< 30);
  localparam longint T4  = (T3 * H) / (longint'(4) <<< 30);
  localparam longint T5  = (T4 * H) / (longint'(5) <<< 30);
  localparam longint T6  = (T5 * H) / (longint'(6) <<< 30);
  localparam longint T7  = (T6 * H) / (longint'(7) <<< 30);
  localparam longint T8  = (T7 * H) / (longint'(8) <<< 30);
  localparam longint T9  = (T8 * H) / (longint'(9) <<< 30);
  localparam longint T10 = (T9 * H) / (longint'(10) <<< 30);
  localparam longint T11 = (T10 * H) / (longint'(11) <<< 30);
  localparam longint T12 = (T11 * H) / (longint'(12) <<< 30);
  localparam longint T13 = (T12 * H) / (longint'(13) <<< 30);
  localparam longint T14 = (T13 * H) / (longint'(14) <<< 30);
  localparam longint R = Q30 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10 - T11
                         + T12 - T13 + T14;

  logic [G_W-1:0] tab [EXP_TABLE_DEPTH+1];

  for (genvar e = 0; e <= EXP_TABLE_DEPTH; e++) begin : g_tab
    assign tab[e] = exp_entry(R, e);
  end

  logic [41:0]     plo_q, phi_q;
  logic [59:0]     a;
  logic [59:0]     ar;
  logic [P_W-1:0]  p;
  logic [TI_W-1:0] idx_q;
  logic [19:0]     frac_q;
  logic            zb_q, zc_q;
  logic [G_W-1:0]  t0, t1, t0_q;
  logic [50:0]     prod_q;
  logic [G_W-1:0]  g_q;

  assign a  = 60'(plo_q) + (60'(phi_q) << 18);
  assign ar = a + 60'(1 << 19);
  assign p  = P_W'(ar[39:20]) * P_W'(EXP_TABLE_DEPTH);
  assign t0 = tab[idx_q];
  assign t1 = tab[idx_q + TI_W'(1)];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= 42'(coef_i) * 42'(d_i[17:0]);
      phi_q  <= 42'(coef_i) * 42'(d_i[35:18]);
      idx_q  <= p[20 +: TI_W];
      frac_q <= p[19:0];
      zb_q   <= |ar[59:40];
      t0_q   <= t0;
      prod_q <= 51'(t0 - t1) * 51'(frac_q);
      zc_q   <= zb_q;
      g_q    <= zc_q ? '0 : t0_q - prod_q[50:20];
    end
  end

  assign g_o = g_q;

endmodule
`default_nettype wire

// ----- rtl/gabor_frequency_kernel_filter_top.sv -----
`default_nettype none
// Gabor kernel filter for one frequency-domain pixel per transaction. A new pixel is
// taken every clock while stall_o is low, and the pipeline holds while the output
// is stalled. Writing image_width or image_height starts a bit-serial divider for
// the 2*pi/N step, during which stall_o is high; other register writes take effect
// at once.
module gabor_frequency_kernel_filter_top import gfk_pkg::*; #(
  parameter int MAX_DIM = 512,
  parameter int SAMPLE_BITS = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic [8:0]                    pix_row_i,
  input  wire logic [8:0]                    pix_col_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_re_o,
  output logic signed [SAMPLE_BITS-1:0]      out_im_o,
  output logic                               in_support_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int OFF_W = DIM_W + 2;
  localparam int PX_W = OFF_W + NUM_W + 1;
  localparam int LAT = 11;
  localparam logic [NUM_W-1:0] STEP_RST = NUM_W'((105414357 + 64) / 128);
  localparam longint SHI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SLO = -SHI - 1;

  logic signed [15:0] cx_q, cy_q;
  logic [23:0]        coef_q, pref_q, eps_q;
  logic               dc_q;
  logic [9:0]         width_q, height_q;
  logic [32:0]        cc_q;
  logic signed [31:0] sq_cx, sq_cy;

  function automatic logic [DIM_W-1:0] used_size(input logic [9:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  logic [DIM_W-1:0] uw, uh, un_new;
  logic             busy_x, busy_y, busy;
  logic [NUM_W-1:0] step_x, step_y;
  logic             start_x, start_y;

  assign uw      = used_size(width_q);
  assign uh      = used_size(height_q);
  assign un_new  = used_size(cfg_data_i[9:0]);
  assign start_x = cfg_we_i && cfg_idx_i == CFG_WIDTH;
  assign start_y = cfg_we_i && cfg_idx_i == CFG_HEIGHT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      coef_q   <= 24'd8192;
      pref_q   <= 24'd65536;
      dc_q     <= 1'b1;
      eps_q    <= 24'd1;
      width_q  <= 10'd128;
      height_q <= 10'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: cx_q     <= cfg_data_i[15:0];
        CFG_CENTER_Y: cy_q     <= cfg_data_i[15:0];
        CFG_GAUSS:    coef_q   <= cfg_data_i;
        CFG_PREFAC:   pref_q   <= cfg_data_i;
        CFG_DC_FREE:  dc_q     <= cfg_data_i[0];
        CFG_EPSILON:  eps_q    <= cfg_data_i;
        CFG_WIDTH:    width_q  <= cfg_data_i[9:0];
        CFG_HEIGHT:   height_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign sq_cx = cx_q * cx_q;
  assign sq_cy = cy_q * cy_q;

  always_ff @(posedge clk_i) begin
    cc_q <= 33'($unsigned(sq_cx)) + 33'($unsigned(sq_cy));
  end

  gfk_div #(.DIM_W(DIM_W), .RST_Q(STEP_RST)) u_div_x (
    .clk_i, .rst_ni, .start_i(start_x), .n_i(un_new), .busy_o(busy_x), .q_o(step_x)
  );
  gfk_div #(.DIM_W(DIM_W), .RST_Q(STEP_RST)) u_div_y (
    .clk_i, .rst_ni, .start_i(start_y), .n_i(un_new), .busy_o(busy_y), .q_o(step_y)
  );

  assign busy = busy_x || busy_y;

  logic adv;
  logic [LAT-1:0] v_q;
  logic signed [SAMPLE_BITS-1:0] re_q [9];
  logic signed [SAMPLE_BITS-1:0] im_q [9];
  logic [7:0] oob_q;

  assign adv     = !(v_q[LAT-1] && out_stall_i);
  assign stall_o = !adv || busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], valid_i && !busy};
    end
  end

  logic [DIM_W:0]          hx, hy;
  logic signed [OFF_W-1:0] offx, offy;
  logic signed [PX_W-1:0]  px_q, py_q;
  logic                    oob;

  assign hx   = ({1'b0, uw} + (DIM_W+1)'(1)) >> 1;
  assign hy   = ({1'b0, uh} + (DIM_W+1)'(1)) >> 1;
  assign offx = ((DIM_W+1)'(pix_col_i) < hx) ? OFF_W'(pix_col_i)
                : OFF_W'(pix_col_i) - OFF_W'(uw);
  assign offy = ((DIM_W+1)'(pix_row_i) < hy) ? OFF_W'(pix_row_i)
                : OFF_W'(pix_row_i) - OFF_W'(uh);
  assign oob  = (13'(pix_row_i) >= 13'(uh)) || (13'(pix_col_i) >= 13'(uw));

  logic signed [F_W-1:0]   fx, fy, fx_q, fy_q;
  logic signed [F_W:0]     dx_q, dy_q;
  logic signed [33:0]      sq_dx, sq_dy, sq_fx, sq_fy;
  logic [D_W-1:0]          d1_q, d2_q;
  logic [G_W-1:0]          g1, g2;
  logic signed [31:0]      gd;
  logic signed [56:0]      pm_q;
  logic signed [63:0]      vr;
  logic signed [25:0]      val, val_q, mag;
  logic                    sup_q, sup2_q;
  logic signed [SAMPLE_BITS+25:0] mr_q, mi_q;
  logic signed [63:0]      rr, ri;

  assign fx = F_W'(rnd_shr(64'(px_q), 12));
  assign fy = F_W'(rnd_shr(64'(py_q), 12));
  assign sq_dx = dx_q * dx_q;
  assign sq_dy = dy_q * dy_q;
  assign sq_fx = fx_q * fx_q;
  assign sq_fy = fy_q * fy_q;
  assign gd = $signed({1'b0, g1}) - (dc_q ? $signed({1'b0, g2}) : 32'sd0);
  assign vr = rnd_shr(64'(pm_q), 30);
  assign val = vr[25:0];
  assign mag = val < 0 ? -val : val;
  assign rr = rnd_shr(64'(mr_q), 16);
  assign ri = rnd_shr(64'(mi_q), 16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q[0] <= sample_re_i;
      im_q[0] <= sample_im_i;
      for (int k = 1; k < 9; k++) begin
        re_q[k] <= re_q[k-1];
        im_q[k] <= im_q[k-1];
      end
      oob_q <= {oob_q[6:0], oob};
      px_q  <= offx * $signed({1'b0, step_x});
      py_q  <= offy * $signed({1'b0, step_y});
      fx_q  <= fx;
      fy_q  <= fy;
      dx_q  <= (F_W+1)'(fx) - (F_W+1)'(cx_q);
      dy_q  <= (F_W+1)'(fy) - (F_W+1)'(cy_q);
      d1_q  <= D_W'($unsigned(sq_dx)) + D_W'($unsigned(sq_dy));
      d2_q  <= D_W'($unsigned(sq_fx)) + D_W'($unsigned(sq_fy)) + D_W'(cc_q);
      pm_q  <= $signed({1'b0, pref_q}) * 57'(gd);
      val_q <= val;
      sup_q <= !oob_q[7] && (mag > $signed({2'b0, eps_q}));
      mr_q  <= re_q[8] * val_q;
      mi_q  <= im_q[8] * val_q;
      sup2_q <= sup_q;
      in_support_o <= sup2_q;
      out_re_o <= !sup2_q ? '0 : rr > SHI ? SAMPLE_BITS'(SHI) : rr < SLO ? SAMPLE_BITS'(SLO)
                  : rr[SAMPLE_BITS-1:0];
      out_im_o <= !sup2_q ? '0 : ri > SHI ? SAMPLE_BITS'(SHI) : ri < SLO ? SAMPLE_BITS'(SLO)
                  : ri[SAMPLE_BITS-1:0];
    end
  end

  gfk_gauss #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_gauss_1 (
    .clk_i, .en_i(adv), .coef_i(coef_q), .d_i(d1_q), .g_o(g1)
  );
  gfk_gauss #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_gauss_2 (
    .clk_i, .en_i(adv), .coef_i(coef_q), .d_i(d2_q), .g_o(g2)
  );

  assign out_valid_o = v_q[LAT-1];

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> stall_o) else $error("input taken during step division");

  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_support_o) |-> (out_re_o == '0 && out_im_o == '0))
    else $error("non-zero result outside support");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(cfg_we_i)) else $error("divider started without write");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> stall_o) else $error("input taken while pipe held");

endmodule
`default_nettype wire
